[rtl/ftach_pkg.sv]
// Shared constants, types and register indexes for the fan tachometer monitor.
package ftach_pkg;

  localparam int CHANNELS      = 3;
  localparam int HISTORY_DEPTH = 10;

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HIST_W  = $clog2(HISTORY_DEPTH);
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int HMEM_DEPTH = CHANNELS * HISTORY_DEPTH;
  localparam int HADDR_W = $clog2(HMEM_DEPTH);

  localparam int RUN_W   = 8;
  localparam int COUNT_W = 16;
  localparam int RPM_W   = 16;
  localparam int THR_W   = 8;
  localparam int WIN_W   = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int RPM_SCALE = 60;
  localparam int SCALE_W   = 6;
  localparam int SUM_W     = COUNT_W + CNT_W;
  localparam int PROD_W    = SUM_W + SCALE_W;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(1);

  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(4);
  localparam logic [WIN_W-1:0] WINDOW_RESET    = WIN_W'(2000);

  typedef struct packed {
    logic               awaiting_high;
    logic [RUN_W-1:0]   run_length;
    logic [COUNT_W-1:0] pulse_count;
  } qual_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [RPM_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/ftach_if.sv]
// Valid/ready channel interfaces for tach samples and speed results.
interface ftach_sample_if;
  logic valid;
  logic ready;
  logic tach_level_0;
  logic tach_level_1;
  logic tach_level_2;

  modport source (output valid, output tach_level_0, output tach_level_1,
                  output tach_level_2, input ready);
  modport sink (input valid, input tach_level_0, input tach_level_1,
                input tach_level_2, output ready);
endinterface

interface ftach_result_if;
  logic                        valid;
  logic                        ready;
  logic [ftach_pkg::RPM_W-1:0] rpm_0;
  logic [ftach_pkg::RPM_W-1:0] rpm_1;
  logic [ftach_pkg::RPM_W-1:0] rpm_2;

  modport source (output valid, output rpm_0, output rpm_1, output rpm_2, input ready);
  modport sink (input valid, input rpm_0, input rpm_1, input rpm_2, output ready);
endinterface

[rtl/ftach_div.sv]
// Bit-serial saturating divider of the scaled pulse sum by the entry count.
module ftach_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ftach_pkg::div_req_t req_i,
  output ftach_pkg::div_rsp_t rsp_o
);

  localparam int HI_W   = ftach_pkg::PROD_W - ftach_pkg::RPM_W;
  localparam int STEP_W = $clog2(ftach_pkg::RPM_W);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic                          state_q;
  logic                          done_q;
  logic [STEP_W-1:0]             step_q;
  logic [ftach_pkg::CNT_W-1:0]   rem_q;
  logic [ftach_pkg::CNT_W-1:0]   div_q;
  logic [ftach_pkg::RPM_W-1:0]   quo_q;
  logic [ftach_pkg::CNT_W:0]     trial;
  logic                          fits;
  logic                          sat;

  assign trial = {rem_q, quo_q[ftach_pkg::RPM_W-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign sat   = req_i.dividend[ftach_pkg::PROD_W-1:ftach_pkg::RPM_W] >= HI_W'(req_i.divisor);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            if (sat) begin
              done_q <= 1'b1;
            end else begin
              state_q <= S_RUN;
              step_q  <= '0;
            end
          end
        end
        S_RUN: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(ftach_pkg::RPM_W - 1)) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.start) begin
      div_q <= req_i.divisor;
      if (sat) begin
        quo_q <= '1;
      end else begin
        rem_q <= req_i.dividend[ftach_pkg::RPM_W +: ftach_pkg::CNT_W];
        quo_q <= req_i.dividend[ftach_pkg::RPM_W-1:0];
      end
    end else if (state_q == S_RUN) begin
      rem_q <= fits ? ftach_pkg::CNT_W'(trial - {1'b0, div_q})
                    : trial[ftach_pkg::CNT_W-1:0];
      quo_q <= {quo_q[ftach_pkg::RPM_W-2:0], fits};
    end
  end

  assign rsp_o.busy     = (state_q == S_RUN);
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[rtl/fan_tach_rpm_monitor_core.sv]
// Fan tachometer monitor: debounced pulse counting per channel and windowed average speed.
// A sample item that does not end a window makes one qualifier memory read-modify-write per
// channel. A window-ending item then also waits on the single history memory read port and
// the 16-step shared divider for each channel.
// Reset clears counters, qualifier valid bits and the history fill count; no clearing pass.
module fan_tach_rpm_monitor_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ftach_sample_if.sink                     sample_i,
  ftach_result_if.source                   result_o,
  input  logic                             cfg_we_i,
  input  logic [ftach_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ftach_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CHN = ftach_pkg::CHANNELS;
  localparam int HD  = ftach_pkg::HISTORY_DEPTH;
  localparam int CHW = ftach_pkg::CH_W;
  localparam int HW  = ftach_pkg::HIST_W;
  localparam int CW  = ftach_pkg::CNT_W;
  localparam int AW  = ftach_pkg::HADDR_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_QUAL   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DWAIT  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  function automatic ftach_pkg::qual_t qualify(ftach_pkg::qual_t s, logic level,
                                               logic [ftach_pkg::THR_W-1:0] thr);
    ftach_pkg::qual_t r;
    r = s;
    if (level != s.awaiting_high) begin
      r.run_length = '0;
    end else begin
      if (s.run_length != '1) begin
        r.run_length = s.run_length + ftach_pkg::RUN_W'(1);
      end
      if (r.run_length > thr) begin
        r.run_length = '0;
        if (s.awaiting_high) begin
          if (s.pulse_count != '1) begin
            r.pulse_count = s.pulse_count + ftach_pkg::COUNT_W'(1);
          end
          r.awaiting_high = 1'b0;
        end else begin
          r.awaiting_high = 1'b1;
        end
      end
    end
    return r;
  endfunction

  logic [2:0]                          state_q, state_d;
  logic [CHW-1:0]                      ch_q, ch_d;
  logic [ftach_pkg::WIN_W-1:0]         tick_q, tick_d;
  logic [ftach_pkg::THR_W-1:0]         thr_q;
  logic [ftach_pkg::WIN_W-1:0]         win_q;
  logic [CHN-1:0]                      lvl_q, lvl_d;
  logic                                win_end_q, win_end_d;
  logic [HW-1:0]                       head_q, head_d;
  logic [CW-1:0]                       fill_q, fill_d;
  logic [CHN-1:0]                      qvalid_q, qvalid_d;
  logic [CW-1:0]                       stp_q, stp_d;
  logic [ftach_pkg::SUM_W-1:0]         sum_q, sum_d;
  logic [CW-1:0]                       n_q, n_d;
  logic                                zlast_q, zlast_d;
  logic [ftach_pkg::PROD_W-1:0]        prod_q, prod_d;
  logic [CHN-1:0][ftach_pkg::RPM_W-1:0] rpm_q, rpm_d;
  logic [CHN-1:0][ftach_pkg::RPM_W-1:0] out_rpm_q, out_rpm_d;
  logic                                out_valid_q, out_valid_d;

  ftach_pkg::qual_t                    qmem [CHN];
  ftach_pkg::qual_t                    qrd_q;
  ftach_pkg::qual_t                    qcur;
  ftach_pkg::qual_t                    qnew;
  ftach_pkg::qual_t                    qwdata;
  logic                                q_we;
  logic                                q_re;
  logic [CHW-1:0]                      q_ra;

  logic [ftach_pkg::COUNT_W-1:0]       hmem [ftach_pkg::HMEM_DEPTH];
  logic [ftach_pkg::COUNT_W-1:0]       hrd_q;
  logic [ftach_pkg::COUNT_W-1:0]       hv;
  logic                                h_we;
  logic                                h_re;
  logic [AW-1:0]                       h_base;
  logic [AW-1:0]                       h_wa;
  logic [AW-1:0]                       h_ra;
  logic [HW:0]                         h_phys_sum;
  logic [HW-1:0]                       h_phys;
  logic [CW-1:0]                       h_pos;

  logic [CHN-1:0]                      levels;
  logic [ftach_pkg::WIN_W:0]           tick_next;
  logic                                last_ch;

  ftach_pkg::div_req_t                 div_req;
  ftach_pkg::div_rsp_t                 div_rsp;

  ftach_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign levels    = {sample_i.tach_level_2, sample_i.tach_level_1, sample_i.tach_level_0};
  assign tick_next = {1'b0, tick_q} + (ftach_pkg::WIN_W + 1)'(1);
  assign last_ch   = (ch_q == CHW'(CHN - 1));

  assign qcur   = qvalid_q[ch_q] ? qrd_q : '0;
  assign qnew   = qualify(qcur, lvl_q[ch_q], thr_q);

  always_comb begin
    qwdata = qnew;
    if (win_end_q) begin
      qwdata.pulse_count = '0;
    end
  end

  assign h_base     = AW'(ch_q) * AW'(HD);
  assign h_wa       = h_base + AW'(head_q);
  assign h_phys_sum = {1'b0, head_q} + {1'b0, stp_q[HW-1:0]};
  assign h_phys     = (h_phys_sum >= (HW + 1)'(HD)) ? HW'(h_phys_sum - (HW + 1)'(HD))
                                                     : h_phys_sum[HW-1:0];
  assign h_ra       = h_base + AW'(h_phys);
  assign h_pos      = stp_q - CW'(1);
  assign hv         = (h_pos >= CW'(HD) - fill_q) ? hrd_q : '0;

  always_comb begin
    state_d          = state_q;
    ch_d             = ch_q;
    tick_d           = tick_q;
    lvl_d            = lvl_q;
    win_end_d        = win_end_q;
    head_d           = head_q;
    fill_d           = fill_q;
    qvalid_d         = qvalid_q;
    stp_d            = stp_q;
    sum_d            = sum_q;
    n_d              = n_q;
    zlast_d          = zlast_q;
    prod_d           = prod_q;
    rpm_d            = rpm_q;
    out_rpm_d        = out_rpm_q;
    out_valid_d      = out_valid_q;
    q_we             = 1'b0;
    q_re             = 1'b0;
    q_ra             = '0;
    h_we             = 1'b0;
    h_re             = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor  = n_q;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (sample_i.valid) begin
          lvl_d     = levels;
          win_end_d = tick_next >= {1'b0, win_q};
          ch_d      = '0;
          q_re      = 1'b1;
          state_d   = S_QUAL;
        end
      end
      S_QUAL: begin
        q_we           = 1'b1;
        qvalid_d[ch_q] = 1'b1;
        h_we           = win_end_q;
        if (!last_ch) begin
          q_re = 1'b1;
          q_ra = ch_q + CHW'(1);
          ch_d = ch_q + CHW'(1);
        end else begin
          ch_d   = '0;
          tick_d = win_end_q ? '0 : tick_next[ftach_pkg::WIN_W-1:0];
          if (win_end_q) begin
            head_d  = (head_q == HW'(HD - 1)) ? '0 : head_q + HW'(1);
            fill_d  = (fill_q == CW'(HD)) ? fill_q : fill_q + CW'(1);
            stp_d   = '0;
            sum_d   = '0;
            n_d     = '0;
            state_d = S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        h_re  = (stp_q < CW'(HD));
        stp_d = stp_q + CW'(1);
        if (stp_q != '0) begin
          if (hv != '0 || n_q != '0) begin
            n_d   = n_q + CW'(1);
            sum_d = sum_q + ftach_pkg::SUM_W'(hv);
          end
          if (stp_q == CW'(HD - 1)) begin
            zlast_d = (hv == '0);
          end
        end
        if (stp_q == CW'(HD)) begin
          if (zlast_q && hv == '0) begin
            rpm_d[ch_q] = '0;
            if (last_ch) begin
              state_d = S_OUT;
            end else begin
              ch_d    = ch_q + CHW'(1);
              stp_d   = '0;
              sum_d   = '0;
              n_d     = '0;
              state_d = S_SCAN;
            end
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_d  = ftach_pkg::PROD_W'(sum_q) * ftach_pkg::PROD_W'(ftach_pkg::RPM_SCALE);
        state_d = S_DSTART;
      end
      S_DSTART: begin
        div_req.start = 1'b1;
        state_d       = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_rsp.done) begin
          rpm_d[ch_q] = div_rsp.quotient;
          if (last_ch) begin
            state_d = S_OUT;
          end else begin
            ch_d    = ch_q + CHW'(1);
            stp_d   = '0;
            sum_d   = '0;
            n_d     = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_rpm_d   = rpm_q;
          out_valid_d = 1'b1;
          ch_d        = '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      tick_q      <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      qvalid_q    <= '0;
      out_valid_q <= 1'b0;
      win_end_q   <= 1'b0;
      thr_q       <= ftach_pkg::THRESHOLD_RESET;
      win_q       <= ftach_pkg::WINDOW_RESET;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      tick_q      <= tick_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      qvalid_q    <= qvalid_d;
      out_valid_q <= out_valid_d;
      win_end_q   <= win_end_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ftach_pkg::REG_THRESHOLD: thr_q <= cfg_data_i[ftach_pkg::THR_W-1:0];
          ftach_pkg::REG_WINDOW:    win_q <= cfg_data_i[ftach_pkg::WIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q     <= lvl_d;
    stp_q     <= stp_d;
    sum_q     <= sum_d;
    n_q       <= n_d;
    zlast_q   <= zlast_d;
    prod_q    <= prod_d;
    rpm_q     <= rpm_d;
    out_rpm_q <= out_rpm_d;
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      qmem[ch_q] <= qwdata;
    end
    if (q_re) begin
      qrd_q <= qmem[q_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hmem[h_wa] <= qnew.pulse_count;
    end
    if (h_re) begin
      hrd_q <= hmem[h_ra];
    end
  end

  assign sample_i.ready  = (state_q == S_IDLE);
  assign result_o.valid  = out_valid_q;
  assign result_o.rpm_0  = out_rpm_q[0];
  assign result_o.rpm_1  = out_rpm_q[1];
  assign result_o.rpm_2  = out_rpm_q[2];

`ifndef SYNTHESIS
  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("Result became valid outside the output state.");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("Divider started while busy.");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DWAIT)
    else $error("Divider finished while no channel was waiting for it.");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(HD))
    else $error("History fill count exceeds the history depth.");

  a_accept_starts_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i.valid && sample_i.ready |=> state_q == S_QUAL && ch_q == '0)
    else $error("Accepted item did not start the qualifier pass.");
`endif

endmodule

[tb/ftach_speed_checker.sv]
// Checker that predicts the fan tachometer speeds and compares every result item.
module ftach_speed_checker
  import ftach_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ftach_sample_if               smp_i,
  ftach_result_if               res_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [RPM_W-1:0] rpm_2;
    logic [RPM_W-1:0] rpm_1;
    logic [RPM_W-1:0] rpm_0;
  } speeds_t;

  logic [THR_W-1:0]   thr;
  logic [WIN_W-1:0]   win;
  logic [WIN_W-1:0]   ticks;
  logic               awaiting_high [CHANNELS];
  logic [RUN_W-1:0]   run_len [CHANNELS];
  logic [COUNT_W-1:0] pulses [CHANNELS];
  logic [COUNT_W-1:0] hist [CHANNELS][HISTORY_DEPTH];
  speeds_t            rpm_expected_q [$];
  int                 fails;

  task automatic debounce_sample(input int ch, input logic level);
    if (level != awaiting_high[ch]) begin
      run_len[ch] = '0;
    end else begin
      if (run_len[ch] != '1) run_len[ch] = run_len[ch] + 1'b1;
      if (run_len[ch] > thr) begin
        run_len[ch] = '0;
        if (awaiting_high[ch]) begin
          if (pulses[ch] != '1) pulses[ch] = pulses[ch] + 1'b1;
          awaiting_high[ch] = 1'b0;
        end else begin
          awaiting_high[ch] = 1'b1;
        end
      end
    end
  endtask

  function automatic logic [RPM_W-1:0] avg_speed(input int ch);
    logic [63:0] total;
    logic [63:0] quo;
    int          n;
    total = '0;
    n = 0;
    if (hist[ch][HISTORY_DEPTH-2] == '0 && hist[ch][HISTORY_DEPTH-1] == '0) return '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (hist[ch][i] != '0 || n != 0) begin
        n++;
        total += hist[ch][i];
      end
    end
    if (n == 0) return '0;
    quo = (total * RPM_SCALE) / n;
    return (quo > 64'hFFFF) ? '1 : quo[RPM_W-1:0];
  endfunction

  task automatic tick_step(input logic [CHANNELS-1:0] levels);
    logic [WIN_W:0] next;
    speeds_t        exp_item;
    for (int ch = 0; ch < CHANNELS; ch++) debounce_sample(ch, levels[ch]);
    next = {1'b0, ticks} + 1'b1;
    if (next < {1'b0, win}) begin
      ticks = next[WIN_W-1:0];
    end else begin
      ticks = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        for (int i = 0; i < HISTORY_DEPTH - 1; i++) hist[ch][i] = hist[ch][i+1];
        hist[ch][HISTORY_DEPTH-1] = pulses[ch];
        pulses[ch] = '0;
      end
      exp_item.rpm_0 = avg_speed(0);
      exp_item.rpm_1 = avg_speed(1);
      exp_item.rpm_2 = avg_speed(2);
      rpm_expected_q.push_back(exp_item);
    end
  endtask

  task automatic check_result();
    speeds_t exp_item;
    if (rpm_expected_q.size() == 0) begin
      $error("result item with no expectation: rpm_0 %0d rpm_1 %0d rpm_2 %0d",
             res_i.rpm_0, res_i.rpm_1, res_i.rpm_2);
      fails++;
    end else begin
      exp_item = rpm_expected_q.pop_front();
      if (res_i.rpm_0 !== exp_item.rpm_0) begin
        $error("rpm_0: expected %0d, actual %0d", exp_item.rpm_0, res_i.rpm_0);
        fails++;
      end
      if (res_i.rpm_1 !== exp_item.rpm_1) begin
        $error("rpm_1: expected %0d, actual %0d", exp_item.rpm_1, res_i.rpm_1);
        fails++;
      end
      if (res_i.rpm_2 !== exp_item.rpm_2) begin
        $error("rpm_2: expected %0d, actual %0d", exp_item.rpm_2, res_i.rpm_2);
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr   = THRESHOLD_RESET;
      win   = WINDOW_RESET;
      ticks = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        awaiting_high[ch] = 1'b0;
        run_len[ch]       = '0;
        pulses[ch]        = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) hist[ch][i] = '0;
      end
      rpm_expected_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_THRESHOLD: thr = cfg_data_i[THR_W-1:0];
          REG_WINDOW:    win = cfg_data_i[WIN_W-1:0];
          default: ;
        endcase
      end
      if (smp_i.valid && smp_i.ready) begin
        tick_step({smp_i.tach_level_2, smp_i.tach_level_1, smp_i.tach_level_0});
      end
      if (res_i.valid && res_i.ready) check_result();
      fail_count_o <= fails;
      pending_o    <= rpm_expected_q.size();
    end
  end

endmodule

[tb/tb_top.sv]
// Top of the fan tachometer monitor testbench: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ftach_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  int   burst_left;
  int   stall_mode;
  int   stall_left;
  int   thr_now;
  logic wave_lvl [3];
  int   wave_left [3];

  ftach_sample_if smp ();
  ftach_result_if res ();

  fan_tach_rpm_monitor_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (smp),
    .result_o   (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  ftach_speed_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .smp_i        (smp),
    .res_i        (res),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       res.ready <= 1'b1;
      1:       res.ready <= 1'($urandom_range(0, 1));
      2:       res.ready <= ($urandom_range(0, 3) == 0);
      default: res.ready <= ((stall_left % 7) < 3);
    endcase
  end

  task automatic send_sample(input logic [2:0] levels);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        smp.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    smp.valid        <= 1'b1;
    smp.tach_level_0 <= levels[0];
    smp.tach_level_1 <= levels[1];
    smp.tach_level_2 <= levels[2];
    @(posedge clk_i);
    while (!smp.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    smp.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(data);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_THRESHOLD) thr_now = data & 8'hFF;
  endtask

  // Runs a little longer than the threshold make pulses; shorter runs act as glitches.
  function automatic logic [2:0] shaped_levels(input int noise_pct);
    logic [2:0] levels;
    for (int ch = 0; ch < 3; ch++) begin
      if (wave_left[ch] == 0) begin
        wave_lvl[ch] = ~wave_lvl[ch];
        if ($urandom_range(0, 99) < 85) wave_left[ch] = thr_now + 1 + $urandom_range(0, 3);
        else wave_left[ch] = $urandom_range(1, thr_now + 1);
      end
      wave_left[ch]--;
      levels[ch] = wave_lvl[ch];
      if ($urandom_range(0, 99) < noise_pct) levels[ch] = 1'($urandom_range(0, 1));
    end
    return levels;
  endfunction

  initial begin
    int rand_items;
    int n;
    int r;
    int noise;
    smp.valid        = 1'b0;
    smp.tach_level_0 = 1'b0;
    smp.tach_level_1 = 1'b0;
    smp.tach_level_2 = 1'b0;
    res.ready        = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    rst_ni           = 1'b0;
    burst_left       = 0;
    stall_mode       = 0;
    stall_left       = 0;
    thr_now          = 4;
    rand_items       = 0;
    for (int ch = 0; ch < 3; ch++) begin
      wave_lvl[ch]  = 1'b1;
      wave_left[ch] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(REG_SPARE_2, 16'hFFFF);
    write_reg(REG_SPARE_3, 16'h00AA);
    write_reg(REG_THRESHOLD, 16'hAB00);
    write_reg(REG_WINDOW, 0);
    send_sample(3'b000);
    send_sample(3'b111);
    send_sample(3'b000);
    send_sample(3'b111);
    send_sample(3'b010);
    send_sample(3'b101);
    wait_drained();

    write_reg(REG_THRESHOLD, 2);
    write_reg(REG_WINDOW, 8);
    send_sample(3'b000);
    send_sample(3'b000);
    send_sample(3'b001);
    send_sample(3'b000);
    send_sample(3'b000);
    send_sample(3'b000);
    send_sample(3'b111);
    send_sample(3'b111);
    send_sample(3'b011);
    send_sample(3'b111);
    send_sample(3'b111);
    wait_drained();

    write_reg(REG_WINDOW, 65535);
    repeat (4) send_sample(3'($urandom_range(0, 7)));
    wait_drained();
    write_reg(REG_WINDOW, 2);
    send_sample(3'b110);
    wait_drained();

    // Empty windows clear the history so one busy window alone sets the speed.
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_WINDOW, 1);
    repeat (11) send_sample(3'b000);
    wait_drained();
    write_reg(REG_WINDOW, 200);
    for (int i = 0; i < 200; i++) begin
      send_sample({1'($urandom_range(0, 1)), 1'(i), 1'(i)});
    end
    wait_drained();

    write_reg(REG_THRESHOLD, 255);
    write_reg(REG_WINDOW, 60);
    repeat (60) send_sample({1'($urandom_range(0, 1)), 2'b10});
    wait_drained();

    while (rand_items < 650) begin
      wait_drained();
      if ($urandom_range(0, 4) != 0) begin
        r = $urandom_range(0, 99);
        if (r < 60) write_reg(REG_THRESHOLD, $urandom_range(0, 3));
        else if (r < 90) write_reg(REG_THRESHOLD, $urandom_range(4, 10));
        else if (r < 95) write_reg(REG_THRESHOLD, 255);
        else write_reg(REG_THRESHOLD, $urandom_range(11, 30));
        r = $urandom_range(0, 99);
        if (r < 75) write_reg(REG_WINDOW, $urandom_range(1, 24));
        else if (r < 92) write_reg(REG_WINDOW, $urandom_range(25, 80));
        else if (r < 96) write_reg(REG_WINDOW, 0);
        else write_reg(REG_WINDOW, $urandom_range(100, 300));
      end
      if ($urandom_range(0, 9) == 0) begin
        write_reg(REG_WINDOW, 65535);
        n = $urandom_range(3, 20);
        repeat (n) begin
          send_sample(shaped_levels(5));
          rand_items++;
        end
        wait_drained();
        write_reg(REG_WINDOW, $urandom_range(0, n));
      end
      noise = ($urandom_range(0, 5) == 0) ? 50 : $urandom_range(0, 5);
      n = $urandom_range(30, 120);
      repeat (n) begin
        send_sample(shaped_levels(noise));
        rand_items++;
      end
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

[files.f]
rtl/ftach_pkg.sv
rtl/ftach_if.sv
rtl/ftach_div.sv
rtl/fan_tach_rpm_monitor_core.sv
tb/ftach_speed_checker.sv
tb/tb_top.sv
